### hdl/mfe_pkg.sv
// mfe_pkg: shared types, constants and helpers of the mesh feature edge extractor
// used by mfe_ctrl, mfe_datapath and the top level; no dependencies

package mfe_pkg;

    // edge table size, a power of two
    localparam int EDGE_SLOTS = 4096;
    localparam int SLOT_W     = $clog2(EDGE_SLOTS);
    localparam int CNT_W      = SLOT_W + 1;
    localparam int COUNT_W    = 13;
    localparam int COUNT_MAX  = 8191;

    // coordinate and cross product widths
    localparam int COORD_BITS = 24;
    localparam int DIFF_W     = COORD_BITS + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int MAG_W      = PROD_W + 1;

    localparam logic [63:0] FNV_OFFSET  = 64'd1469598103934665603;
    localparam logic [63:0] FNV_LOW     = 64'h1B3;
    localparam int          FNV_SHIFT   = 40;
    localparam logic [63:0] SCALE_LIMIT = 64'd1 << 30;
    localparam logic [15:0] CREASE_RESET = 16'd30802;

    typedef enum logic [1:0] {
        CMD_ADD   = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2,
        CMD_NOP   = 2'd3
    } cmd_t;

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_DIFF, ST_CROSS, ST_MAG, ST_SCALE, ST_SUMSQ, ST_SQRT,
        ST_DIV_INIT, ST_DIV, ST_HASH, ST_EKEY, ST_PROBE_RD, ST_PROBE_CHK, ST_DOT,
        ST_DOT_WR, ST_NEXT_EDGE, ST_RD_ADDR, ST_RD_CHK, ST_RD_OUT
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_ACCEPT, OP_CLEAR, OP_DIFF, OP_CROSS, OP_MAG, OP_SCALE, OP_SUMSQ,
        OP_SQRT, OP_DIV_INIT, OP_DIV, OP_HASH, OP_EKEY, OP_PROBE_RD, OP_PROBE_CHK,
        OP_DOT, OP_DOT_WR, OP_NEXT_EDGE, OP_RD_ADDR, OP_RD_CHK, OP_EMIT
    } dp_op_t;

    // one edge table entry
    typedef struct packed {
        logic        valid;
        logic [63:0] key;
        logic [63:0] ends;
        logic [47:0] normal;
        logic [1:0]  faces;
        logic        crease;
    } slot_t;

    // datapath status seen by the controller
    typedef struct packed {
        logic corner_full;
        logic big;
        logic degen;
        logic cross_last;
        logic sumsq_last;
        logic sqrt_last;
        logic div_last;
        logic k_last;
        logic hash_last;
        logic empty;
        logic match;
        logic probe_last;
        logic solid;
        logic dot_last;
        logic e_last;
        logic cur_end;
        logic feature;
        logic clr_last;
        logic out_free;
    } dp_status_t;

    // multiply by the 64-bit hash prime, which is 2^40 + 0x1b3
    function automatic logic [63:0] fnv_mul(input logic [63:0] x);
        logic [63:0] lowp;
        lowp = 64'(x * FNV_LOW);
        return (x << FNV_SHIFT) + lowp;
    endfunction

    function automatic logic [63:0] sext64(input logic [COORD_BITS-1:0] x);
        return {{(64-COORD_BITS){x[COORD_BITS-1]}}, x};
    endfunction

endpackage

### hdl/mfe_ctrl.sv
// mfe_ctrl: sequencing state machine of the mesh feature edge extractor
// depends on mfe_pkg; drives datapath ops, reads datapath status

module mfe_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  mfe_pkg::cmd_t       in_cmd,
    input  mfe_pkg::dp_status_t st,
    output logic                in_ready,
    output mfe_pkg::dp_op_t     op
);

    mfe_pkg::state_t state_reg, state_next;

    // state register, reset starts the table clearing pass
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mfe_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state and datapath op
    always_comb begin
        state_next = state_reg;
        op         = mfe_pkg::OP_NONE;
        in_ready   = 1'b0;
        unique case (state_reg)
            mfe_pkg::ST_CLEAR: begin
                op = mfe_pkg::OP_CLEAR;
                if (st.clr_last) state_next = mfe_pkg::ST_IDLE;
            end
            mfe_pkg::ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    op = mfe_pkg::OP_ACCEPT;
                    case (in_cmd)
                        mfe_pkg::CMD_ADD: begin
                            if (st.corner_full) state_next = mfe_pkg::ST_DIFF;
                        end
                        mfe_pkg::CMD_READ:  state_next = mfe_pkg::ST_RD_ADDR;
                        mfe_pkg::CMD_CLEAR: state_next = mfe_pkg::ST_CLEAR;
                        default: ;
                    endcase
                end
            end
            mfe_pkg::ST_DIFF: begin
                op = mfe_pkg::OP_DIFF;
                state_next = mfe_pkg::ST_CROSS;
            end
            mfe_pkg::ST_CROSS: begin
                op = mfe_pkg::OP_CROSS;
                if (st.cross_last) state_next = mfe_pkg::ST_MAG;
            end
            mfe_pkg::ST_MAG: begin
                op = mfe_pkg::OP_MAG;
                state_next = mfe_pkg::ST_SCALE;
            end
            mfe_pkg::ST_SCALE: begin
                op = mfe_pkg::OP_SCALE;
                if (st.degen) state_next = mfe_pkg::ST_HASH;
                else if (!st.big) state_next = mfe_pkg::ST_SUMSQ;
            end
            mfe_pkg::ST_SUMSQ: begin
                op = mfe_pkg::OP_SUMSQ;
                if (st.sumsq_last) state_next = mfe_pkg::ST_SQRT;
            end
            mfe_pkg::ST_SQRT: begin
                op = mfe_pkg::OP_SQRT;
                if (st.sqrt_last) state_next = mfe_pkg::ST_DIV_INIT;
            end
            mfe_pkg::ST_DIV_INIT: begin
                op = mfe_pkg::OP_DIV_INIT;
                state_next = mfe_pkg::ST_DIV;
            end
            mfe_pkg::ST_DIV: begin
                op = mfe_pkg::OP_DIV;
                if (st.div_last) begin
                    state_next = st.k_last ? mfe_pkg::ST_HASH : mfe_pkg::ST_DIV_INIT;
                end
            end
            mfe_pkg::ST_HASH: begin
                op = mfe_pkg::OP_HASH;
                if (st.hash_last) state_next = mfe_pkg::ST_EKEY;
            end
            mfe_pkg::ST_EKEY: begin
                op = mfe_pkg::OP_EKEY;
                state_next = mfe_pkg::ST_PROBE_RD;
            end
            mfe_pkg::ST_PROBE_RD: begin
                op = mfe_pkg::OP_PROBE_RD;
                state_next = mfe_pkg::ST_PROBE_CHK;
            end
            mfe_pkg::ST_PROBE_CHK: begin
                op = mfe_pkg::OP_PROBE_CHK;
                if (st.empty) state_next = mfe_pkg::ST_NEXT_EDGE;
                else if (st.match) begin
                    state_next = st.solid ? mfe_pkg::ST_DOT : mfe_pkg::ST_NEXT_EDGE;
                end else if (st.probe_last) state_next = mfe_pkg::ST_NEXT_EDGE;
                else state_next = mfe_pkg::ST_PROBE_RD;
            end
            mfe_pkg::ST_DOT: begin
                op = mfe_pkg::OP_DOT;
                if (st.dot_last) state_next = mfe_pkg::ST_DOT_WR;
            end
            mfe_pkg::ST_DOT_WR: begin
                op = mfe_pkg::OP_DOT_WR;
                state_next = mfe_pkg::ST_NEXT_EDGE;
            end
            mfe_pkg::ST_NEXT_EDGE: begin
                op = mfe_pkg::OP_NEXT_EDGE;
                state_next = st.e_last ? mfe_pkg::ST_IDLE : mfe_pkg::ST_EKEY;
            end
            mfe_pkg::ST_RD_ADDR: begin
                op = mfe_pkg::OP_RD_ADDR;
                state_next = st.cur_end ? mfe_pkg::ST_RD_OUT : mfe_pkg::ST_RD_CHK;
            end
            mfe_pkg::ST_RD_CHK: begin
                op = mfe_pkg::OP_RD_CHK;
                state_next = st.feature ? mfe_pkg::ST_RD_OUT : mfe_pkg::ST_RD_ADDR;
            end
            mfe_pkg::ST_RD_OUT: begin
                if (st.out_free) begin
                    op = mfe_pkg::OP_EMIT;
                    state_next = mfe_pkg::ST_IDLE;
                end
            end
            default: state_next = mfe_pkg::ST_CLEAR;
        endcase
    end

endmodule

### hdl/mfe_datapath.sv
// mfe_datapath: normal unit, weld hashing, edge table memory and result register
// depends on mfe_pkg; sequenced by mfe_ctrl through dp_op_t

module mfe_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  mfe_pkg::dp_op_t                op,
    input  mfe_pkg::cmd_t                  in_cmd,
    input  logic [31:0]                    in_index,
    input  logic [23:0]                    in_px,
    input  logic [23:0]                    in_py,
    input  logic [23:0]                    in_pz,
    input  logic                           cfg_wr_en,
    input  logic [15:0]                    cfg_wr_data,
    input  logic                           out_ready,
    output mfe_pkg::dp_status_t            st,
    output logic                           out_valid,
    output logic [31:0]                    out_first,
    output logic [31:0]                    out_second,
    output logic                           out_done,
    output logic [mfe_pkg::COUNT_W-1:0]    out_count,
    output logic                           out_ovf
);

    localparam int CB = mfe_pkg::COORD_BITS;
    localparam int DW = mfe_pkg::DIFF_W;
    localparam int MW = mfe_pkg::MAG_W;
    localparam int SW = mfe_pkg::SLOT_W;
    localparam int CW = mfe_pkg::CNT_W;

    // control state
    logic [15:0]            crease_reg;
    logic [1:0]             corner_cnt_reg;
    logic                   m_valid_reg;
    logic [CW-1:0]          distinct_reg;
    logic                   ovf_reg;
    logic [CW-1:0]          cursor_reg;
    logic [SW-1:0]          clr_reg;

    // triangle and normal payload
    logic signed [CB-1:0]   pc_reg [3][3];
    logic [31:0]            idx_reg [3];
    logic signed [DW-1:0]   u_reg [3];
    logic signed [DW-1:0]   v_reg [3];
    logic signed [MW-1:0]   c_reg [3];
    logic [MW-1:0]          mag_reg [3];
    logic                   neg_reg [3];
    logic [2:0]             cs_reg;
    logic [1:0]             sk_reg;
    logic [61:0]            acc_reg;
    logic [63:0]            sx_reg, sr_reg, sb_reg;
    logic [31:0]            rem_reg;
    logic [16:0]            low_reg;
    logic [16:0]            q_reg;
    logic [4:0]             ds_reg;
    logic [1:0]             nk_reg;
    logic signed [15:0]     n_reg [3];
    logic                   solid_reg;

    // hashing and probing payload
    logic [1:0]             hc_reg, hd_reg;
    logic [63:0]            key_reg [3];
    logic [1:0]             e_reg;
    logic [63:0]            ekey_reg;
    logic [63:0]            ends_reg;
    logic [SW-1:0]          slot_reg;
    logic [SW-1:0]          probe_reg;
    mfe_pkg::slot_t         hold_reg;
    logic [1:0]             dk_reg;
    logic signed [33:0]     dot_reg;
    logic [31:0]            res_first_reg, res_second_reg;
    logic                   res_done_reg;
    logic [31:0]            m_first_reg, m_second_reg;
    logic                   m_done_reg;
    logic [mfe_pkg::COUNT_W-1:0] m_count_reg;
    logic                   m_ovf_reg;

    // edge table
    mfe_pkg::slot_t         mem [mfe_pkg::EDGE_SLOTS];
    mfe_pkg::slot_t         rd_reg;
    logic                   rd_en, wr_en;
    logic [SW-1:0]          rd_addr, wr_addr;
    mfe_pkg::slot_t         wr_data;

    // combinational helpers
    logic signed [DW-1:0]   ma, mb;
    logic signed [mfe_pkg::PROD_W-1:0] cprod;
    logic [1:0]             ck;
    logic                   csub;
    logic [29:0]            sq_op;
    logic [59:0]            sq_prod;
    logic [61:0]            sq_sum;
    logic [63:0]            s_t;
    logic [30:0]            len;
    logic [45:0]            num;
    logic [31:0]            r2;
    logic                   qb;
    logic [16:0]            qf;
    logic [15:0]            qsat;
    logic signed [CB-1:0]   hcoord;
    logic [63:0]            hkey_in;
    logic [1:0]             e_nx;
    logic [63:0]            klo, khi;
    mfe_pkg::slot_t         upd;
    mfe_pkg::slot_t         fresh;
    logic [1:0]             faces_inc;
    logic signed [15:0]     hn;
    logic signed [31:0]     dprod;
    logic [33:0]            dabs;
    logic                   feat;

    // cross product operand schedule
    always_comb begin
        ma = u_reg[1]; mb = v_reg[2]; ck = 2'd0; csub = 1'b0;
        case (cs_reg)
            3'd0: begin ma = u_reg[1]; mb = v_reg[2]; ck = 2'd0; csub = 1'b0; end
            3'd1: begin ma = u_reg[2]; mb = v_reg[1]; ck = 2'd0; csub = 1'b1; end
            3'd2: begin ma = u_reg[2]; mb = v_reg[0]; ck = 2'd1; csub = 1'b0; end
            3'd3: begin ma = u_reg[0]; mb = v_reg[2]; ck = 2'd1; csub = 1'b1; end
            3'd4: begin ma = u_reg[0]; mb = v_reg[1]; ck = 2'd2; csub = 1'b0; end
            default: begin ma = u_reg[1]; mb = v_reg[0]; ck = 2'd2; csub = 1'b1; end
        endcase
        cprod = ma * mb;
    end

    // sum of squares, square root step, division step
    always_comb begin
        sq_op   = 30'(mag_reg[sk_reg]);
        sq_prod = sq_op * sq_op;
        sq_sum  = acc_reg + 62'(sq_prod);
        s_t     = sr_reg + sb_reg;
        len     = 31'(sr_reg);
        num     = {1'b0, 30'(mag_reg[nk_reg]), 15'd0} + 46'(len >> 1);
        r2      = {rem_reg[30:0], low_reg[16]};
        qb      = (r2 >= {1'b0, len});
        qf      = {q_reg[15:0], qb};
        qsat    = (qf > 17'd32767) ? 16'd32767 : qf[15:0];
    end

    // hashing and edge key
    always_comb begin
        hcoord  = pc_reg[hc_reg][hd_reg];
        hkey_in = (hd_reg == 2'd0) ? mfe_pkg::FNV_OFFSET : key_reg[hc_reg];
        e_nx    = (e_reg == 2'd2) ? 2'd0 : e_reg + 2'd1;
        klo     = key_reg[e_reg];
        khi     = key_reg[e_nx];
        if (klo > khi) begin
            klo = key_reg[e_nx];
            khi = key_reg[e_reg];
        end
    end

    // table entry updates and dot product step
    always_comb begin
        faces_inc    = (rd_reg.faces == 2'd3) ? 2'd3 : rd_reg.faces + 2'd1;
        upd          = rd_reg;
        upd.faces    = faces_inc;
        fresh.valid  = 1'b1;
        fresh.key    = ekey_reg;
        fresh.ends   = ends_reg;
        fresh.normal = {n_reg[2], n_reg[1], n_reg[0]};
        fresh.faces  = 2'd1;
        fresh.crease = 1'b0;
        hn           = hold_reg.normal[{dk_reg, 4'd0} +: 16];
        dprod        = hn * n_reg[dk_reg];
        dabs         = dot_reg[33] ? 34'(-dot_reg) : 34'(dot_reg);
        feat         = rd_reg.valid && (rd_reg.faces != 2'd2 || rd_reg.crease);
    end

    // memory port control
    always_comb begin
        rd_en   = 1'b0;
        rd_addr = slot_reg;
        wr_en   = 1'b0;
        wr_addr = slot_reg;
        wr_data = upd;
        unique case (op)
            mfe_pkg::OP_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = clr_reg;
                wr_data = '0;
            end
            mfe_pkg::OP_PROBE_RD: rd_en = 1'b1;
            mfe_pkg::OP_PROBE_CHK: begin
                if (!rd_reg.valid) begin
                    wr_en   = 1'b1;
                    wr_data = fresh;
                end else if (rd_reg.key == ekey_reg && !solid_reg) begin
                    wr_en = 1'b1;
                end
            end
            mfe_pkg::OP_DOT_WR: begin
                wr_en          = 1'b1;
                wr_data        = hold_reg;
                wr_data.crease = hold_reg.crease | (dabs < {3'd0, crease_reg, 15'd0});
            end
            mfe_pkg::OP_RD_ADDR: begin
                rd_en   = !cursor_reg[SW];
                rd_addr = cursor_reg[SW-1:0];
            end
            default: ;
        endcase
    end

    // edge table storage
    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (rd_en) rd_reg <= mem[rd_addr];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crease_reg     <= mfe_pkg::CREASE_RESET;
            corner_cnt_reg <= 2'd0;
            m_valid_reg    <= 1'b0;
            distinct_reg   <= '0;
            ovf_reg        <= 1'b0;
            cursor_reg     <= '0;
            clr_reg        <= '0;
        end else begin
            if (cfg_wr_en) crease_reg <= cfg_wr_data;
            if (op == mfe_pkg::OP_EMIT) m_valid_reg <= 1'b1;
            else if (out_ready) m_valid_reg <= 1'b0;
            unique case (op)
                mfe_pkg::OP_CLEAR: clr_reg <= clr_reg + 1'b1;
                mfe_pkg::OP_ACCEPT: begin
                    if (in_cmd == mfe_pkg::CMD_ADD) begin
                        corner_cnt_reg <= (corner_cnt_reg == 2'd2) ? 2'd0
                                                                   : corner_cnt_reg + 2'd1;
                    end else if (in_cmd == mfe_pkg::CMD_CLEAR) begin
                        corner_cnt_reg <= 2'd0;
                        cursor_reg     <= '0;
                        distinct_reg   <= '0;
                        ovf_reg        <= 1'b0;
                        clr_reg        <= '0;
                    end
                end
                mfe_pkg::OP_DIFF: cursor_reg <= '0;
                mfe_pkg::OP_PROBE_CHK: begin
                    if (!rd_reg.valid) distinct_reg <= distinct_reg + 1'b1;
                    else if (rd_reg.key != ekey_reg && st.probe_last) ovf_reg <= 1'b1;
                end
                mfe_pkg::OP_RD_CHK: cursor_reg <= cursor_reg + 1'b1;
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        unique case (op)
            mfe_pkg::OP_ACCEPT: begin
                if (in_cmd == mfe_pkg::CMD_ADD) begin
                    pc_reg[corner_cnt_reg][0] <= in_px[CB-1:0];
                    pc_reg[corner_cnt_reg][1] <= in_py[CB-1:0];
                    pc_reg[corner_cnt_reg][2] <= in_pz[CB-1:0];
                    idx_reg[corner_cnt_reg]   <= in_index;
                end
            end
            mfe_pkg::OP_DIFF: begin
                for (int i = 0; i < 3; i++) begin
                    u_reg[i] <= DW'(pc_reg[1][i]) - DW'(pc_reg[0][i]);
                    v_reg[i] <= DW'(pc_reg[2][i]) - DW'(pc_reg[0][i]);
                end
                cs_reg    <= 3'd0;
                solid_reg <= 1'b1;
                hc_reg    <= 2'd0;
                hd_reg    <= 2'd0;
                e_reg     <= 2'd0;
            end
            mfe_pkg::OP_CROSS: begin
                c_reg[ck] <= csub ? c_reg[ck] - MW'(cprod) : MW'(cprod);
                cs_reg    <= cs_reg + 3'd1;
            end
            mfe_pkg::OP_MAG: begin
                for (int i = 0; i < 3; i++) begin
                    mag_reg[i] <= c_reg[i][MW-1] ? MW'(-c_reg[i]) : MW'(c_reg[i]);
                    neg_reg[i] <= c_reg[i][MW-1];
                end
            end
            mfe_pkg::OP_SCALE: begin
                if (st.degen) begin
                    for (int i = 0; i < 3; i++) n_reg[i] <= '0;
                    solid_reg <= 1'b0;
                end else if (st.big) begin
                    for (int i = 0; i < 3; i++) mag_reg[i] <= mag_reg[i] >> 1;
                end else begin
                    sk_reg  <= 2'd0;
                    acc_reg <= '0;
                    nk_reg  <= 2'd0;
                end
            end
            mfe_pkg::OP_SUMSQ: begin
                acc_reg <= sq_sum;
                sk_reg  <= sk_reg + 2'd1;
                if (st.sumsq_last) begin
                    sx_reg <= 64'(sq_sum);
                    sr_reg <= '0;
                    sb_reg <= 64'd1 << 62;
                end
            end
            mfe_pkg::OP_SQRT: begin
                if (sx_reg >= s_t) begin
                    sx_reg <= sx_reg - s_t;
                    sr_reg <= (sr_reg >> 1) + sb_reg;
                end else begin
                    sr_reg <= sr_reg >> 1;
                end
                sb_reg <= sb_reg >> 2;
                sk_reg <= 2'd0;
            end
            mfe_pkg::OP_DIV_INIT: begin
                sk_reg  <= nk_reg;
                rem_reg <= 32'(num >> 17);
                low_reg <= num[16:0];
                q_reg   <= '0;
                ds_reg  <= '0;
            end
            mfe_pkg::OP_DIV: begin
                rem_reg <= qb ? r2 - {1'b0, len} : r2;
                low_reg <= {low_reg[15:0], 1'b0};
                q_reg   <= qf;
                ds_reg  <= ds_reg + 5'd1;
                if (st.div_last) begin
                    n_reg[nk_reg] <= neg_reg[nk_reg] ? -$signed(qsat) : $signed(qsat);
                    nk_reg        <= nk_reg + 2'd1;
                end
            end
            mfe_pkg::OP_HASH: begin
                key_reg[hc_reg] <= mfe_pkg::fnv_mul(hkey_in ^ mfe_pkg::sext64(hcoord));
                if (hd_reg == 2'd2) begin
                    hd_reg <= 2'd0;
                    hc_reg <= hc_reg + 2'd1;
                end else begin
                    hd_reg <= hd_reg + 2'd1;
                end
            end
            mfe_pkg::OP_EKEY: begin
                ekey_reg  <= mfe_pkg::fnv_mul(klo) ^ khi;
                slot_reg  <= SW'(mfe_pkg::fnv_mul(klo) ^ khi);
                probe_reg <= '0;
                ends_reg  <= {idx_reg[e_nx], idx_reg[e_reg]};
            end
            mfe_pkg::OP_PROBE_CHK: begin
                hold_reg  <= upd;
                dk_reg    <= 2'd0;
                dot_reg   <= '0;
                // advance only on a miss, a hit keeps the slot for the crease write
                if (rd_reg.valid && rd_reg.key != ekey_reg) begin
                    slot_reg  <= slot_reg + 1'b1;
                    probe_reg <= probe_reg + 1'b1;
                end
            end
            mfe_pkg::OP_DOT: begin
                dot_reg <= dot_reg + 34'(dprod);
                dk_reg  <= dk_reg + 2'd1;
            end
            mfe_pkg::OP_NEXT_EDGE: e_reg <= e_reg + 2'd1;
            mfe_pkg::OP_RD_ADDR: begin
                if (cursor_reg[SW]) begin
                    res_first_reg  <= '0;
                    res_second_reg <= '0;
                    res_done_reg   <= 1'b1;
                end
            end
            mfe_pkg::OP_RD_CHK: begin
                if (feat) begin
                    res_first_reg  <= rd_reg.ends[31:0];
                    res_second_reg <= rd_reg.ends[63:32];
                    res_done_reg   <= 1'b0;
                end
            end
            mfe_pkg::OP_EMIT: begin
                m_first_reg  <= res_first_reg;
                m_second_reg <= res_second_reg;
                m_done_reg   <= res_done_reg;
                m_count_reg  <= (32'(distinct_reg) > 32'(mfe_pkg::COUNT_MAX))
                              ? mfe_pkg::COUNT_W'(mfe_pkg::COUNT_MAX)
                              : mfe_pkg::COUNT_W'(distinct_reg);
                m_ovf_reg    <= ovf_reg;
            end
            default: ;
        endcase
    end

    // status to the controller
    always_comb begin
        st.corner_full = (corner_cnt_reg == 2'd2);
        st.big         = (64'(mag_reg[0]) >= mfe_pkg::SCALE_LIMIT) ||
                         (64'(mag_reg[1]) >= mfe_pkg::SCALE_LIMIT) ||
                         (64'(mag_reg[2]) >= mfe_pkg::SCALE_LIMIT);
        st.degen       = (mag_reg[0] == '0) && (mag_reg[1] == '0) && (mag_reg[2] == '0);
        st.cross_last  = (cs_reg == 3'd5);
        st.sumsq_last  = (sk_reg == 2'd2);
        st.sqrt_last   = sb_reg[0];
        st.div_last    = (ds_reg == 5'd16);
        st.k_last      = (nk_reg == 2'd2);
        st.hash_last   = (hc_reg == 2'd2) && (hd_reg == 2'd2);
        st.empty       = !rd_reg.valid;
        st.match       = (rd_reg.key == ekey_reg);
        st.probe_last  = (probe_reg == SW'(mfe_pkg::EDGE_SLOTS - 1));
        st.solid       = solid_reg;
        st.dot_last    = (dk_reg == 2'd2);
        st.e_last      = (e_reg == 2'd2);
        st.cur_end     = cursor_reg[SW];
        st.feature     = feat;
        st.clr_last    = (clr_reg == SW'(mfe_pkg::EDGE_SLOTS - 1));
        st.out_free    = !m_valid_reg || out_ready;
    end

    assign out_valid  = m_valid_reg;
    assign out_first  = m_first_reg;
    assign out_second = m_second_reg;
    assign out_done   = m_done_reg;
    assign out_count  = m_count_reg;
    assign out_ovf    = m_ovf_reg;

endmodule

### hdl/mesh_feature_edge_extractor.sv
// a first or second corner is only stored; a third corner runs the triangle through
// the normal unit (cross product, scaling, sum of squares, square root, divide), the
// vertex hashing, then per edge a table probe, plus a dot product on a repeat edge
// a table read scans slots up to the next feature edge; a new beat is taken only once
// the command before it is done; reset and the clear command run a pass over the
// edge table, no beats are taken meanwhile; aresetn is synchronous and active low

module mesh_feature_edge_extractor (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [103:0] s_axis_tdata,  // vertex_index, pos_x, pos_y, pos_z
    input  logic [1:0]   s_axis_tuser,  // cmd
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [79:0]  m_axis_tdata,  // edge_first, edge_second, edges_considered,
                                        // overflowed, zero pad
    output logic [0:0]   m_axis_tuser,  // done_res
    input  logic         cfg_wr_en,
    input  logic [15:0]  cfg_wr_data
);

    mfe_pkg::dp_op_t     op;
    mfe_pkg::dp_status_t st;
    mfe_pkg::cmd_t       cmd;
    logic [31:0]         first, second;
    logic                done;
    logic [mfe_pkg::COUNT_W-1:0] count;
    logic                ovf;

    assign cmd = mfe_pkg::cmd_t'(s_axis_tuser);

    // sequencing
    mfe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_axis_tvalid),
        .in_cmd   (cmd),
        .st       (st),
        .in_ready (s_axis_tready),
        .op       (op)
    );

    // arithmetic and table
    mfe_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (op),
        .in_cmd      (cmd),
        .in_index    (s_axis_tdata[31:0]),
        .in_px       (s_axis_tdata[55:32]),
        .in_py       (s_axis_tdata[79:56]),
        .in_pz       (s_axis_tdata[103:80]),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_ready   (m_axis_tready),
        .st          (st),
        .out_valid   (m_axis_tvalid),
        .out_first   (first),
        .out_second  (second),
        .out_done    (done),
        .out_count   (count),
        .out_ovf     (ovf)
    );

    // result beat packing
    assign m_axis_tdata = {2'd0, ovf, count, second, first};
    assign m_axis_tuser = done;

`ifndef SYNTH
    // a read command keeps the input closed while the scan runs
    a_read_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready && s_axis_tuser == mfe_pkg::CMD_READ
        |=> !s_axis_tready)
        else $error("input open right after a read beat");

    // a done beat carries zero edge ends
    a_done_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[63:0] == 64'd0)
        else $error("done beat with edge ends");

    // edge count never exceeds the table size
    a_count_max: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> 32'(m_axis_tdata[76:64]) <= 32'(mfe_pkg::EDGE_SLOTS))
        else $error("edge count above table size");
`endif

endmodule

### bench/mesh_feature_edge_extractor_tb.sv
// mesh_feature_edge_extractor_tb: self-checking bench for the feature edge extractor
// drives corner/read/clear/nop beats, predicts every read beat, depends on mfe_pkg and the rtl

`timescale 1ns / 100ps

module mesh_feature_edge_extractor_tb;

    localparam int             QUIET_LIMIT = 200000;
    localparam logic [63:0]    HASH_PRIME  = 64'd1099511628211;
    localparam logic [63:0]    HASH_BASIS  = 64'd1469598103934665603;

    typedef struct {
        logic [31:0] first;
        logic [31:0] second;
        logic        done;
        logic [12:0] count;
        logic        ovf;
    } edge_beat_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [103:0] s_axis_tdata = '0;   // vertex_index, pos_x, pos_y, pos_z
    logic [1:0]   s_axis_tuser = '0;   // cmd
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [79:0]  m_axis_tdata;        // edge_first, edge_second, edges_considered,
                                       // overflowed, zero pad
    logic [0:0]   m_axis_tuser;        // done_res
    logic         cfg_wr_en = 1'b0;
    logic [15:0]  cfg_wr_data = '0;

    // edge table mirror
    bit          tbl_valid [mfe_pkg::EDGE_SLOTS];
    logic [63:0] tbl_key   [mfe_pkg::EDGE_SLOTS];
    logic [31:0] tbl_a     [mfe_pkg::EDGE_SLOTS];
    logic [31:0] tbl_b     [mfe_pkg::EDGE_SLOTS];
    int          tbl_n     [mfe_pkg::EDGE_SLOTS][3];
    int          tbl_faces [mfe_pkg::EDGE_SLOTS];
    bit          tbl_crease[mfe_pkg::EDGE_SLOTS];

    int          corners;
    longint      tri_pos[3][3];
    logic [31:0] tri_idx[3];
    int          tri_norm[3];
    bit          tri_solid;
    int          cursor;
    int          n_edges;
    bit          ovf_flag;
    logic [15:0] crease_cos;

    edge_beat_t  pending_edges[$];
    int          send_idle_pct;
    int          recv_idle_pct;
    int          errors;
    int          quiet;

    // vertex pool for well-formed meshes
    longint      pool_pos[10][3];
    logic [31:0] pool_idx[10];

    mesh_feature_edge_extractor u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always #2 aclk = ~aclk;

    // ---------------- predictor ----------------

    function automatic logic [63:0] int_sqrt(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // unit normal of tri_pos into tri_norm / tri_solid
    function automatic void face_normal();
        longint      u[3];
        longint      v[3];
        longint      c[3];
        logic [63:0] m[3];
        logic [63:0] mx;
        logic [63:0] sum;
        logic [63:0] len;
        logic [63:0] q;
        int          sh;
        for (int i = 0; i < 3; i++) begin
            u[i] = tri_pos[1][i] - tri_pos[0][i];
            v[i] = tri_pos[2][i] - tri_pos[0][i];
        end
        c[0] = u[1] * v[2] - u[2] * v[1];
        c[1] = u[2] * v[0] - u[0] * v[2];
        c[2] = u[0] * v[1] - u[1] * v[0];
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = (c[i] < 0) ? 64'(-c[i]) : 64'(c[i]);
            if (m[i] > mx) mx = m[i];
        end
        tri_solid = (mx != 0);
        tri_norm = '{0, 0, 0};
        if (!tri_solid) return;
        sh = 0;
        while ((mx >> sh) >= (64'd1 << 30)) sh++;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = m[i] >> sh;
            sum = sum + m[i] * m[i];
        end
        len = int_sqrt(sum);
        for (int i = 0; i < 3; i++) begin
            q = (m[i] * 64'd32768 + len / 2) / len;
            if (q > 64'd32767) q = 64'd32767;
            tri_norm[i] = (c[i] < 0) ? -int'(q) : int'(q);
        end
    endfunction

    function automatic logic [63:0] weld_hash(int k);
        logic [63:0] h;
        h = HASH_BASIS;
        for (int i = 0; i < 3; i++) begin
            h = h ^ 64'(tri_pos[k][i]);
            h = h * HASH_PRIME;
        end
        return h;
    endfunction

    function automatic void table_insert(logic [63:0] key, logic [31:0] a, logic [31:0] b);
        int     s;
        longint dot;
        s = int'(key[mfe_pkg::SLOT_W-1:0]);
        for (int p = 0; p < mfe_pkg::EDGE_SLOTS; p++) begin
            if (!tbl_valid[s]) begin
                tbl_valid[s] = 1;
                tbl_key[s] = key;
                tbl_a[s] = a;
                tbl_b[s] = b;
                for (int k = 0; k < 3; k++) tbl_n[s][k] = tri_norm[k];
                tbl_faces[s] = 1;
                tbl_crease[s] = 0;
                n_edges++;
                return;
            end
            if (tbl_key[s] == key) begin
                if (tbl_faces[s] < 3) tbl_faces[s]++;
                if (tri_solid) begin
                    dot = 0;
                    for (int k = 0; k < 3; k++)
                        dot += longint'(tbl_n[s][k]) * longint'(tri_norm[k]);
                    if (dot < 0) dot = -dot;
                    if (dot < (longint'(crease_cos) << 15)) tbl_crease[s] = 1;
                end
                return;
            end
            s = (s + 1) % mfe_pkg::EDGE_SLOTS;
        end
        ovf_flag = 1;
    endfunction

    function automatic void clear_mirror();
        for (int i = 0; i < mfe_pkg::EDGE_SLOTS; i++) tbl_valid[i] = 0;
        corners = 0;
        cursor = 0;
        n_edges = 0;
        ovf_flag = 0;
    endfunction

    // apply one accepted input beat to the mirror
    function automatic void predict_beat(mfe_pkg::cmd_t cmd, logic [103:0] d);
        logic [63:0] keys[3];
        logic [63:0] lo;
        logic [63:0] hi;
        edge_beat_t  r;
        int          nx;
        int          s;
        case (cmd)
            mfe_pkg::CMD_ADD: begin
                tri_idx[corners] = d[31:0];
                tri_pos[corners][0] = longint'(signed'(d[55:32]));
                tri_pos[corners][1] = longint'(signed'(d[79:56]));
                tri_pos[corners][2] = longint'(signed'(d[103:80]));
                if (corners < 2) begin
                    corners++;
                end else begin
                    face_normal();
                    for (int e = 0; e < 3; e++) keys[e] = weld_hash(e);
                    for (int e = 0; e < 3; e++) begin
                        nx = (e + 1) % 3;
                        lo = keys[e];
                        hi = keys[nx];
                        if (lo > hi) begin
                            lo = keys[nx];
                            hi = keys[e];
                        end
                        table_insert((lo * HASH_PRIME) ^ hi, tri_idx[e], tri_idx[nx]);
                    end
                    cursor = 0;
                    corners = 0;
                end
            end
            mfe_pkg::CMD_READ: begin
                r.first = 0;
                r.second = 0;
                r.done = 1;
                while (cursor < mfe_pkg::EDGE_SLOTS) begin
                    s = cursor;
                    cursor++;
                    if (tbl_valid[s] && (tbl_faces[s] != 2 || tbl_crease[s])) begin
                        r.first = tbl_a[s];
                        r.second = tbl_b[s];
                        r.done = 0;
                        break;
                    end
                end
                r.count = (n_edges > mfe_pkg::COUNT_MAX) ? 13'(mfe_pkg::COUNT_MAX)
                                                         : 13'(n_edges);
                r.ovf = ovf_flag;
                pending_edges = {pending_edges, r};
            end
            mfe_pkg::CMD_CLEAR: clear_mirror();
            default: ;
        endcase
    endfunction

    // ---------------- result checker ----------------

    always @(negedge aclk) begin
        edge_beat_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (pending_edges.size() == 0) begin
                $error("unexpected result beat %h", m_axis_tdata);
                errors++;
            end else begin
                want = pending_edges.pop_front();
                if (m_axis_tdata[31:0] !== want.first) begin
                    $error("edge_first exp %h got %h", want.first, m_axis_tdata[31:0]);
                    errors++;
                end
                if (m_axis_tdata[63:32] !== want.second) begin
                    $error("edge_second exp %h got %h", want.second, m_axis_tdata[63:32]);
                    errors++;
                end
                if (m_axis_tuser[0] !== want.done) begin
                    $error("done_res exp %b got %b", want.done, m_axis_tuser[0]);
                    errors++;
                end
                if (m_axis_tdata[76:64] !== want.count) begin
                    $error("edges_considered exp %0d got %0d", want.count,
                           m_axis_tdata[76:64]);
                    errors++;
                end
                if (m_axis_tdata[77] !== want.ovf) begin
                    $error("overflowed exp %b got %b", want.ovf, m_axis_tdata[77]);
                    errors++;
                end
            end
        end
    end

    // receiver backpressure
    always @(posedge aclk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // watchdog on cycles with no beat on either side
    always @(negedge aclk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet = 0;
        end else begin
            quiet++;
            if (quiet >= QUIET_LIMIT) begin
                $display("mesh_feature_edge_extractor regression: fail");
                $finish;
            end
        end
    end

    // ---------------- stimulus helpers ----------------

    task automatic send_beat(mfe_pkg::cmd_t cmd, logic [31:0] idx, longint x, longint y,
                             longint z);
        int gap;
        bit ok;
        gap = ($urandom_range(99) < send_idle_pct) ? $urandom_range(1, 4) : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= cmd;
        s_axis_tdata <= {z[23:0], y[23:0], x[23:0], idx};
        do begin
            @(negedge aclk);
            ok = s_axis_tready;
            if (ok) predict_beat(mfe_pkg::cmd_t'(s_axis_tuser), s_axis_tdata);
            @(posedge aclk);
        end while (!ok);
    endtask

    task automatic send_corner(logic [31:0] idx, longint x, longint y, longint z);
        send_beat(mfe_pkg::CMD_ADD, idx, x, y, z);
    endtask

    task automatic send_cmd(mfe_pkg::cmd_t cmd);
        send_beat(cmd, $urandom, $urandom, $urandom, $urandom);
    endtask

    // hold the input low until all read beats are back
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        @(posedge aclk);
        while (pending_edges.size() != 0) @(posedge aclk);
    endtask

    // a read is only taken once the block is idle, so its beat proves idle
    task automatic drain();
        send_cmd(mfe_pkg::CMD_READ);
        wait_results();
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_crease(logic [15:0] v);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        crease_cos = v;
        @(posedge aclk);
    endtask

    task automatic read_all(int n);
        for (int i = 0; i < n; i++) send_cmd(mfe_pkg::CMD_READ);
    endtask

    function automatic longint rand_coord();
        return longint'(signed'(24'($urandom)));
    endfunction

    // ---------------- tests ----------------

    task automatic test_extremes_and_commands();
        // full-range coords and indices, repeated done, unused command, clear
        send_corner(32'h0, -8388608, -8388608, -8388608);
        send_corner(32'hFFFF_FFFF, 8388607, -8388608, 8388607);
        send_corner(32'h5555_AAAA, -8388608, 8388607, 8388607);
        read_all(5);
        send_cmd(mfe_pkg::CMD_NOP);
        send_cmd(mfe_pkg::CMD_CLEAR);
        read_all(2);
    endtask

    task automatic test_degenerate_and_crease();
        // collinear face first, so the shared edge keeps a zero normal
        send_corner(1, 0, 0, 0);
        send_corner(2, 1000, 0, 0);
        send_corner(3, 2000, 0, 0);
        send_corner(2, 1000, 0, 0);
        send_corner(1, 0, 0, 0);
        send_corner(4, 0, 1000, 0);
        // perpendicular face on edge 1-2, then one more for face count saturation
        send_corner(1, 0, 0, 0);
        send_corner(2, 1000, 0, 0);
        send_corner(5, 0, 0, 1000);
        send_corner(2, 1000, 0, 0);
        send_corner(1, 0, 0, 0);
        send_corner(6, 0, -1000, 0);
        read_all(6);
    endtask

    task automatic test_crease_settings();
        logic [15:0] vals[4];
        vals = '{16'd0, 16'd32768, 16'hFFFF, 16'd20000};
        foreach (vals[i]) begin
            write_crease(vals[i]);
            send_cmd(mfe_pkg::CMD_CLEAR);
            test_degenerate_and_crease();
        end
        write_crease(mfe_pkg::CREASE_RESET);
    endtask

    task automatic test_random_mesh(int n_items);
        int sent;
        int a;
        int b;
        int c;
        int pick[3];
        int r;
        for (int i = 0; i < 10; i++) begin
            pool_idx[i] = $urandom;
            for (int k = 0; k < 3; k++) pool_pos[i][k] = rand_coord() >>> $urandom_range(0, 14);
        end
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 70) begin
                // well-formed triangle from the shared pool
                a = $urandom_range(9);
                do b = $urandom_range(9); while (b == a);
                do c = $urandom_range(9); while (c == a || c == b);
                pick = '{a, b, c};
                foreach (pick[k])
                    send_corner(pool_idx[pick[k]], pool_pos[pick[k]][0],
                                pool_pos[pick[k]][1], pool_pos[pick[k]][2]);
                sent += 3;
            end else if (r < 90) begin
                read_all($urandom_range(1, 3));
                sent += 2;
            end else if (r < 94) begin
                send_corner($urandom, rand_coord(), rand_coord(), rand_coord());
                sent++;
            end else if (r < 96) begin
                send_cmd(mfe_pkg::CMD_CLEAR);
                sent++;
            end else if (r < 98) begin
                send_cmd(mfe_pkg::CMD_NOP);
                sent++;
            end else begin
                wait_results();
            end
        end
        read_all(4);
    endtask

    initial begin
        errors = 0;
        quiet = 0;
        send_idle_pct = 16;
        recv_idle_pct = 55;
        crease_cos = mfe_pkg::CREASE_RESET;
        for (int i = 0; i < mfe_pkg::EDGE_SLOTS; i++) tbl_valid[i] = 0;
        clear_mirror();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_extremes_and_commands();
        test_degenerate_and_crease();
        test_crease_settings();

        test_random_mesh(100);
        drain();
        send_idle_pct = 55;
        recv_idle_pct = 16;
        test_random_mesh(100);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_mesh(80);

        s_axis_tvalid <= 1'b0;
        while (pending_edges.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (errors == 0) begin
            $display("mesh_feature_edge_extractor regression: pass");
        end else begin
            $display("mesh_feature_edge_extractor regression: fail");
        end
        $finish;
    end

endmodule
